>>> design/gbsi_pkg.sv
// Shared types, widths and command codes of the bilinear grid sampler.
// No dependencies; the top level and gbsi_mul use this package.
package gbsi_pkg;

    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 16;
    localparam int IDX_W    = 8;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int CNT_W    = IDX_W + 1;
    localparam int OP_W     = 64;
    localparam int HALF_W   = OP_W / 2;
    localparam int ACC_W    = 2 * OP_W;
    localparam int QF_W     = ACC_W - FRAC_W;
    localparam int Q_W      = 49;
    localparam int T_W      = Q_W + 1;
    localparam int W_W      = T_W + 1;
    localparam int WO_W     = W_W + 1;
    localparam int SUM_W    = SAMPLE_W + 2;

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_INTERP = 3'd2;
    localparam logic [2:0] CMD_ADD    = 3'd3;
    localparam logic [2:0] CMD_SET    = 3'd4;

    localparam logic [2:0] CFG_ORIGIN_Z = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_X = 3'd1;
    localparam logic [2:0] CFG_INV_Z    = 3'd2;
    localparam logic [2:0] CFG_INV_X    = 3'd3;
    localparam logic [2:0] CFG_ROWS     = 3'd4;
    localparam logic [2:0] CFG_COLS     = 3'd5;

    typedef struct packed {
        logic            start;
        logic            neg;
        logic [OP_W-1:0] ua;
        logic [OP_W-1:0] ub;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic [Q_W-1:0]             q;
        logic signed [SAMPLE_W-1:0] val;
        logic                       flag;
    } mul_rsp_t;

endpackage

>>> design/grid_bilinear_sample_and_inject.sv
// Top level of the bilinear grid sampler: command sequencer, config registers,
// grid RAM (gbsi_ram) and shared multiplier (gbsi_mul). Uses gbsi_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  in       | in_valid / in_stall   | command, coord_z, coord_x, grid_row, grid_col,
//           |                       | sample_value
//  out      | out_valid / out_stall | result_value, saturated
//  config   | cfg_write             | cfg_index, cfg_data
//
// Load writes the grid RAM on accept. Read registers the RAM word and presents it.
// Interpolate and inject use the shared multiplier for 10 products (each: issue, 4
// partial products, rounding, handoff) and the single grid RAM port (a read state
// before each of the 4 corner products, writes overlap the handoff); in_stall stays
// high until the command ends. After reset a clearing pass writes zero to all 65536
// entries, in_stall is high meanwhile. A waiting result holds in the output register;
// the next request is taken meanwhile, and a new result waits until out_stall drops.
module grid_bilinear_sample_and_inject (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic signed [31:0] coord_z,
    input  logic signed [31:0] coord_x,
    input  logic [7:0]  grid_row,
    input  logic [7:0]  grid_col,
    input  logic signed [31:0] sample_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] result_value,
    output logic        saturated,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_READ      = 4'd2;
    localparam logic [3:0] ST_NORM_GO   = 4'd3;
    localparam logic [3:0] ST_NORM_WAIT = 4'd4;
    localparam logic [3:0] ST_WT_GO     = 4'd5;
    localparam logic [3:0] ST_WT_WAIT   = 4'd6;
    localparam logic [3:0] ST_RD        = 4'd7;
    localparam logic [3:0] ST_MUL_GO    = 4'd8;
    localparam logic [3:0] ST_MUL_WAIT  = 4'd9;
    localparam logic [3:0] ST_OUT       = 4'd10;

    localparam int SW = gbsi_pkg::SAMPLE_W;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [31:0] origin_z_reg;
    logic signed [31:0] origin_x_reg;
    logic [31:0] inv_z_reg;
    logic [31:0] inv_x_reg;
    logic [gbsi_pkg::CNT_W-1:0] rows_reg;
    logic [gbsi_pkg::CNT_W-1:0] cols_reg;

    logic [gbsi_pkg::ADDR_W-1:0] clr_reg;
    logic [2:0]  cmd_reg;
    logic signed [31:0] cz_reg;
    logic signed [31:0] cx_reg;
    logic signed [SW-1:0] val_reg;
    logic        axis_reg;
    logic [1:0]  k_reg;
    logic [gbsi_pkg::IDX_W-1:0] iz_reg;
    logic [gbsi_pkg::IDX_W-1:0] ix_reg;
    logic signed [gbsi_pkg::W_W-1:0] wz_reg;
    logic signed [gbsi_pkg::W_W-1:0] wx_reg;
    logic signed [SW-1:0] wt_reg [4];
    logic signed [gbsi_pkg::SUM_W-1:0] sum_reg;
    logic signed [SW-1:0] old_reg;
    logic signed [SW-1:0] res_reg;
    logic        flag_reg;
    logic        out_valid_reg;
    logic signed [SW-1:0] out_val_reg;
    logic        out_sat_reg;

    logic        accept;
    logic        mem_we;
    logic [gbsi_pkg::ADDR_W-1:0] mem_addr;
    logic [SW-1:0] mem_wdata;
    logic [SW-1:0] mem_rdata;
    logic [gbsi_pkg::ADDR_W-1:0] addr_k;

    gbsi_pkg::mul_req_t req;
    gbsi_pkg::mul_rsp_t rsp;

    logic signed [32:0] delta;
    logic [32:0] delta_mag;
    logic [gbsi_pkg::CNT_W-1:0] n_use;
    logic [gbsi_pkg::CNT_W-1:0] n_m2;
    logic signed [gbsi_pkg::T_W-1:0] tn;
    logic [gbsi_pkg::IDX_W-1:0] loc_i;
    logic signed [gbsi_pkg::W_W-1:0] loc_w;
    logic signed [gbsi_pkg::WO_W-1:0] wa;
    logic signed [gbsi_pkg::WO_W-1:0] wb;
    logic [gbsi_pkg::WO_W-1:0] wa_mag;
    logic [gbsi_pkg::WO_W-1:0] wb_mag;
    logic signed [SW-1:0] va;
    logic signed [SW-1:0] vb;
    logic [SW:0] va_mag;
    logic [SW:0] vb_mag;
    logic signed [gbsi_pkg::SUM_W-1:0] sum_next;
    logic signed [SW:0] add_s;
    logic [SW-1:0] add_sat;
    logic        add_ovf;
    logic        sum_ovf;
    logic [SW-1:0] sum_sat;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign addr_k   = {ix_reg + {7'd0, k_reg[0]}, iz_reg + {7'd0, k_reg[1]}};

    always_comb
    begin
        delta     = axis_reg ? ({cx_reg[31], cx_reg} - {origin_x_reg[31], origin_x_reg})
                             : ({cz_reg[31], cz_reg} - {origin_z_reg[31], origin_z_reg});
        delta_mag = delta[32] ? 33'(-delta) : 33'(delta);

        n_use = axis_reg ? cols_reg : rows_reg;
        if (n_use < 9'd2)
        begin
            n_use = 9'd2;
        end
        else if (n_use > 9'd256)
        begin
            n_use = 9'd256;
        end
        n_m2 = n_use - 9'd2;

        tn = delta[32] ? -$signed({1'b0, rsp.q}) : $signed({1'b0, rsp.q});
        if (tn[gbsi_pkg::T_W-1])
        begin
            loc_i = '0;
        end
        else if (tn[gbsi_pkg::T_W-2:gbsi_pkg::FRAC_W] > {25'd0, n_m2[7:0]})
        begin
            loc_i = n_m2[7:0];
        end
        else
        begin
            loc_i = tn[gbsi_pkg::FRAC_W+7:gbsi_pkg::FRAC_W];
        end
        loc_w = {tn[gbsi_pkg::T_W-1], tn} - $signed({27'd0, loc_i, 16'd0});

        wa = k_reg[0] ? {wx_reg[gbsi_pkg::W_W-1], wx_reg}
                      : ($signed({35'd0, 17'h10000}) - {wx_reg[gbsi_pkg::W_W-1], wx_reg});
        wb = k_reg[1] ? {wz_reg[gbsi_pkg::W_W-1], wz_reg}
                      : ($signed({35'd0, 17'h10000}) - {wz_reg[gbsi_pkg::W_W-1], wz_reg});
        wa_mag = wa[gbsi_pkg::WO_W-1] ? gbsi_pkg::WO_W'(-wa) : gbsi_pkg::WO_W'(wa);
        wb_mag = wb[gbsi_pkg::WO_W-1] ? gbsi_pkg::WO_W'(-wb) : gbsi_pkg::WO_W'(wb);

        va = (cmd_reg == gbsi_pkg::CMD_INTERP) ? wt_reg[k_reg] : val_reg;
        vb = (cmd_reg == gbsi_pkg::CMD_INTERP) ? $signed(mem_rdata) : wt_reg[k_reg];
        va_mag = va[SW-1] ? (SW+1)'(-{va[SW-1], va}) : (SW+1)'({va[SW-1], va});
        vb_mag = vb[SW-1] ? (SW+1)'(-{vb[SW-1], vb}) : (SW+1)'({vb[SW-1], vb});

        req = '0;
        case (state_reg)
            ST_NORM_GO:
            begin
                req.start = 1'b1;
                req.neg   = delta[32];
                req.ua    = {31'd0, delta_mag};
                req.ub    = {32'd0, axis_reg ? inv_x_reg : inv_z_reg};
            end
            ST_WT_GO:
            begin
                req.start = 1'b1;
                req.neg   = wa[gbsi_pkg::WO_W-1] ^ wb[gbsi_pkg::WO_W-1];
                req.ua    = {12'd0, wa_mag};
                req.ub    = {12'd0, wb_mag};
            end
            ST_MUL_GO:
            begin
                req.start = 1'b1;
                req.neg   = va[SW-1] ^ vb[SW-1];
                req.ua    = {31'd0, va_mag};
                req.ub    = {31'd0, vb_mag};
            end
            default:
            begin
                req = '0;
            end
        endcase

        sum_next = sum_reg + {{2{rsp.val[SW-1]}}, rsp.val};
        sum_ovf  = (sum_next[gbsi_pkg::SUM_W-1:SW-1] != '0)
                && (sum_next[gbsi_pkg::SUM_W-1:SW-1] != '1);
        sum_sat  = sum_ovf ? {sum_next[gbsi_pkg::SUM_W-1], {(SW-1){!sum_next[gbsi_pkg::SUM_W-1]}}}
                           : sum_next[SW-1:0];
        add_s    = {old_reg[SW-1], old_reg} + {rsp.val[SW-1], rsp.val};
        add_ovf  = add_s[SW] != add_s[SW-1];
        add_sat  = add_ovf ? {add_s[SW], {(SW-1){!add_s[SW]}}} : add_s[SW-1:0];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = addr_k;
        mem_wdata = rsp.val;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                mem_addr  = {grid_col, grid_row};
                mem_wdata = sample_value;
                mem_we    = accept && (command == gbsi_pkg::CMD_LOAD);
            end
            ST_MUL_WAIT:
            begin
                mem_we    = rsp.done && (cmd_reg != gbsi_pkg::CMD_INTERP);
                mem_wdata = (cmd_reg == gbsi_pkg::CMD_ADD) ? add_sat : rsp.val;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == gbsi_pkg::CMD_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if ((command == gbsi_pkg::CMD_INTERP) || (command == gbsi_pkg::CMD_ADD)
                             || (command == gbsi_pkg::CMD_SET))
                    begin
                        state_next = ST_NORM_GO;
                    end
                end
            end
            ST_READ:      state_next = ST_OUT;
            ST_NORM_GO:   state_next = ST_NORM_WAIT;
            ST_NORM_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = axis_reg ? ST_WT_GO : ST_NORM_GO;
                end
            end
            ST_WT_GO:     state_next = ST_WT_WAIT;
            ST_WT_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = (k_reg == 2'd3) ? ST_RD : ST_WT_GO;
                end
            end
            ST_RD:        state_next = ST_MUL_GO;
            ST_MUL_GO:    state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = (k_reg == 2'd3) ? ST_OUT : ST_RD;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            axis_reg      <= 1'b0;
            k_reg         <= '0;
            origin_z_reg  <= '0;
            origin_x_reg  <= '0;
            inv_z_reg     <= 32'd65536;
            inv_x_reg     <= 32'd65536;
            rows_reg      <= 9'd256;
            cols_reg      <= 9'd256;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    gbsi_pkg::CFG_ORIGIN_Z: origin_z_reg <= $signed(cfg_data);
                    gbsi_pkg::CFG_ORIGIN_X: origin_x_reg <= $signed(cfg_data);
                    gbsi_pkg::CFG_INV_Z:    inv_z_reg    <= cfg_data;
                    gbsi_pkg::CFG_INV_X:    inv_x_reg    <= cfg_data;
                    gbsi_pkg::CFG_ROWS:     rows_reg     <= cfg_data[8:0];
                    gbsi_pkg::CFG_COLS:     cols_reg     <= cfg_data[8:0];
                    default:                ;
                endcase
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_OUT) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= 1'b0;
                    k_reg    <= '0;
                end
                ST_NORM_WAIT:
                begin
                    if (rsp.done)
                    begin
                        axis_reg <= 1'b1;
                    end
                end
                ST_WT_WAIT, ST_MUL_WAIT:
                begin
                    if (rsp.done)
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            cz_reg   <= coord_z;
            cx_reg   <= coord_x;
            val_reg  <= sample_value;
            sum_reg  <= '0;
            flag_reg <= 1'b0;
            res_reg  <= '0;
        end
        case (state_reg)
            ST_READ:
            begin
                res_reg <= $signed(mem_rdata);
            end
            ST_NORM_WAIT:
            begin
                if (rsp.done)
                begin
                    if (axis_reg)
                    begin
                        ix_reg <= loc_i;
                        wx_reg <= loc_w;
                    end
                    else
                    begin
                        iz_reg <= loc_i;
                        wz_reg <= loc_w;
                    end
                end
            end
            ST_WT_WAIT:
            begin
                if (rsp.done)
                begin
                    wt_reg[k_reg] <= rsp.val;
                    flag_reg      <= flag_reg | rsp.flag;
                end
            end
            ST_MUL_GO:
            begin
                old_reg <= $signed(mem_rdata);
            end
            ST_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    sum_reg <= sum_next;
                    if (cmd_reg == gbsi_pkg::CMD_INTERP)
                    begin
                        flag_reg <= flag_reg | rsp.flag | ((k_reg == 2'd3) && sum_ovf);
                        if (k_reg == 2'd3)
                        begin
                            res_reg <= $signed(sum_sat);
                        end
                    end
                    else if (cmd_reg == gbsi_pkg::CMD_ADD)
                    begin
                        flag_reg <= flag_reg | rsp.flag | add_ovf;
                    end
                    else
                    begin
                        flag_reg <= flag_reg | rsp.flag;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_val_reg <= res_reg;
                    out_sat_reg <= flag_reg;
                end
            end
            default:
            begin
                old_reg <= old_reg;
            end
        endcase
    end

    gbsi_ram #(
        .WIDTH (gbsi_pkg::SAMPLE_W),
        .DEPTH (gbsi_pkg::DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    gbsi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = out_val_reg;
    assign saturated    = out_sat_reg;

endmodule

>>> design/gbsi_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Standalone; instantiated for the sample grid.
module gbsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/gbsi_mul.sv
// Multi-cycle signed-magnitude multiplier: four 32x32 partial products, then
// a floor shift by the fraction width with 32-bit saturation. Uses gbsi_pkg.
module gbsi_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  gbsi_pkg::mul_req_t req,
    output gbsi_pkg::mul_rsp_t rsp
);

    logic                         busy_reg;
    logic [2:0]                   cnt_reg;
    logic                         neg_reg;
    logic [gbsi_pkg::OP_W-1:0]    ua_reg;
    logic [gbsi_pkg::OP_W-1:0]    ub_reg;
    logic [gbsi_pkg::ACC_W-1:0]   acc_reg;
    logic                         done_reg;
    logic [gbsi_pkg::Q_W-1:0]     q_reg;
    logic signed [gbsi_pkg::SAMPLE_W-1:0] val_reg;
    logic                         flag_reg;

    logic [gbsi_pkg::HALF_W-1:0]  ah;
    logic [gbsi_pkg::HALF_W-1:0]  bh;
    logic [gbsi_pkg::OP_W-1:0]    pp;
    logic [1:0]                   sh;
    logic [gbsi_pkg::ACC_W-1:0]   pp_ext;
    logic [gbsi_pkg::QF_W-1:0]    qf;
    logic                         inc;
    logic                         sat_pos;
    logic                         sat_neg;
    logic [gbsi_pkg::SAMPLE_W-1:0] qlo;

    always_comb
    begin
        ah = cnt_reg[0] ? ua_reg[gbsi_pkg::OP_W-1:gbsi_pkg::HALF_W]
                        : ua_reg[gbsi_pkg::HALF_W-1:0];
        bh = cnt_reg[1] ? ub_reg[gbsi_pkg::OP_W-1:gbsi_pkg::HALF_W]
                        : ub_reg[gbsi_pkg::HALF_W-1:0];
        pp = ah * bh;
        sh = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
        case (sh)
            2'd0:    pp_ext = {{gbsi_pkg::OP_W{1'b0}}, pp};
            2'd1:    pp_ext = {{gbsi_pkg::HALF_W{1'b0}}, pp, {gbsi_pkg::HALF_W{1'b0}}};
            default: pp_ext = {pp, {gbsi_pkg::OP_W{1'b0}}};
        endcase
        inc = neg_reg && (acc_reg[gbsi_pkg::FRAC_W-1:0] != '0);
        qf  = acc_reg[gbsi_pkg::ACC_W-1:gbsi_pkg::FRAC_W] + {{(gbsi_pkg::QF_W-1){1'b0}}, inc};
        qlo = qf[gbsi_pkg::SAMPLE_W-1:0];
        sat_pos = (qf[gbsi_pkg::QF_W-1:gbsi_pkg::SAMPLE_W-1] != '0);
        sat_neg = (qf[gbsi_pkg::QF_W-1:gbsi_pkg::SAMPLE_W] != '0)
               || (qf[gbsi_pkg::SAMPLE_W-1] && (qf[gbsi_pkg::SAMPLE_W-2:0] != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.neg;
            ua_reg  <= req.ua;
            ub_reg  <= req.ub;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd4)
            begin
                q_reg <= qf[gbsi_pkg::Q_W-1:0];
                if (neg_reg)
                begin
                    flag_reg <= sat_neg;
                    val_reg  <= sat_neg ? {1'b1, {(gbsi_pkg::SAMPLE_W-1){1'b0}}}
                                        : $signed(-qlo);
                end
                else
                begin
                    flag_reg <= sat_pos;
                    val_reg  <= sat_pos ? {1'b0, {(gbsi_pkg::SAMPLE_W-1){1'b1}}}
                                        : $signed(qlo);
                end
            end
            else
            begin
                acc_reg <= acc_reg + pp_ext;
            end
        end
    end

    assign rsp = {done_reg, q_reg, val_reg, flag_reg};

endmodule
